// ===== hdl/ppe_pkg.sv =====
// Package for the polyline point evaluator.
// Holds item codes, status codes, the vertex record and the result record.
// No dependencies.
package ppe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = FRAC_BITS + 1;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_EVAL   = 2'd2;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] FLD_X = 2'd0;
  localparam logic [1:0] FLD_Y = 2'd1;
  localparam logic [1:0] FLD_Z = 2'd2;
  localparam logic [1:0] FLD_W = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] weight;
    logic signed [31:0] knot;
  } vertex_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] pweight;
    logic [5:0]         seg_index;
    logic               deriv_ok;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
  } result_t;

  function automatic logic signed [31:0] vertex_field(vertex_t v, logic [1:0] sel);
    logic signed [31:0] f;
    case (sel)
      FLD_X:   f = v.x;
      FLD_Y:   f = v.y;
      FLD_Z:   f = v.z;
      default: f = v.weight;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/ppe_req_if.sv =====
// Request channel of the polyline point evaluator.
// Carries the handshake and the fields of one input item; no dependencies.
interface ppe_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic signed [31:0] vweight;
  logic signed [31:0] vknot;
  logic signed [31:0] param;

  modport source (output valid, func, vx, vy, vz, vweight, vknot, param, input ready);
  modport sink (input valid, func, vx, vy, vz, vweight, vknot, param, output ready);
endinterface

// ===== hdl/ppe_rsp_if.sv =====
// Response channel of the polyline point evaluator.
// Carries the handshake and the fields of one result item; no dependencies.
interface ppe_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic signed [31:0] pweight;
  logic [5:0]         seg_index;
  logic               deriv_ok;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [31:0] dz;

  modport source (output valid, status, px, py, pz, pweight, seg_index, deriv_ok,
                  dx, dy, dz, input ready);
  modport sink (input valid, status, px, py, pz, pweight, seg_index, deriv_ok,
                dx, dy, dz, output ready);
endinterface

// ===== hdl/polyline_point_evaluator.sv =====
// Polyline point evaluator top level.
// Depends on ppe_pkg, ppe_req_if and ppe_rsp_if.
//
// The block keeps a table of up to MAX_POINTS vertices in one memory with a
// write port and a registered read port and takes one item at a time. Clear,
// append and unknown items go from idle straight to the result state, as
// does an evaluate of an empty table. An evaluate reads the first and
// last vertex, scans the table one entry per cycle until the first knot at
// or above the parameter or the end of the table, runs a serial restoring
// divider for the interpolation fraction when a segment of positive length
// is found, and then uses one shared multiplier once per output field,
// multiplying in S_MUL and adding in S_ADD. A result is held in the output
// register until it is taken, and the next item is accepted after that.
module polyline_point_evaluator
  import ppe_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input logic    clk,
  input logic    rst,
  ppe_req_if.sink   req,
  ppe_rsp_if.source rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = $clog2(QUOT_BITS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD0    = 9'b000000010,
    S_RDL    = 9'b000000100,
    S_SCAN   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_ADD    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  vertex_t            mem [MAX_POINTS];
  vertex_t            rdata;
  logic [AW-1:0]      rd_addr;
  vertex_t            prev;
  vertex_t            cur;
  logic signed [31:0] prm;
  logic [AW-1:0]      idx;
  logic               found;
  logic               lo_ok;
  logic               hi_ok;
  logic [33:0]        rem;
  logic [31:0]        dvs;
  logic [QUOT_BITS-1:0] quot;
  logic [DW-1:0]      dcnt;
  logic [QUOT_BITS-1:0] tfrac;
  logic [1:0]         fc;
  logic signed [50:0] prod;
  result_t            res;

  logic               full;
  logic               do_write;
  logic signed [32:0] den;
  logic signed [32:0] num;
  logic [31:0]        num_cl;
  logic [33:0]        trial;
  logic               qbit;
  logic [QUOT_BITS-1:0] quot_next;
  logic signed [31:0] fa;
  logic signed [31:0] fb;
  logic signed [32:0] fdiff;
  logic signed [31:0] fsum;
  logic               deriv;
  logic [AW-1:0]      seg_full;
  logic [5:0]         seg_ext;

  assign full     = (count == CW'(MAX_POINTS));
  assign do_write = (state == S_IDLE) && req.valid && (req.func == FUNC_APPEND) && !full;

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.status    = res.status;
  assign rsp.px        = res.px;
  assign rsp.py        = res.py;
  assign rsp.pz        = res.pz;
  assign rsp.pweight   = res.pweight;
  assign rsp.seg_index = res.seg_index;
  assign rsp.deriv_ok  = res.deriv_ok;
  assign rsp.dx        = res.dx;
  assign rsp.dy        = res.dy;
  assign rsp.dz        = res.dz;

  always_comb begin
    case (state)
      S_RD0:   rd_addr = AW'(count - 1'b1);
      S_RDL:   rd_addr = AW'(1);
      S_SCAN:  rd_addr = AW'(idx + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[AW'(count)] <= '{x: req.vx, y: req.vy, z: req.vz, weight: req.vweight,
                           knot: req.vknot};
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    den = $signed({cur.knot[31], cur.knot}) - $signed({prev.knot[31], prev.knot});
    num = $signed({prm[31], prm}) - $signed({prev.knot[31], prev.knot});
    if (num[32]) begin
      num_cl = '0;
    end else if (num > den) begin
      num_cl = den[31:0];
    end else begin
      num_cl = num[31:0];
    end
    trial     = (dcnt == DW'(QUOT_BITS - 1)) ? rem : {rem[32:0], 1'b0};
    qbit      = (trial >= {2'b00, dvs});
    quot_next = {quot[QUOT_BITS-2:0], qbit};
    fa        = vertex_field(prev, fc);
    fb        = vertex_field(cur, fc);
    fdiff     = $signed({fb[31], fb}) - $signed({fa[31], fa});
    fsum      = fa + $signed(prod[47:16]);
    deriv     = !prm[31] && found;
    seg_full  = AW'(idx - 1'b1);
    seg_ext   = 6'(seg_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            prm <= req.param;
            case (req.func)
              FUNC_CLEAR: begin
                count      <= '0;
                res.status <= ST_LOAD;
                state      <= S_OUT;
              end
              FUNC_APPEND: begin
                if (full) begin
                  res.status <= ST_FULL;
                end else begin
                  count      <= count + 1'b1;
                  res.status <= ST_LOAD;
                end
                state <= S_OUT;
              end
              FUNC_EVAL: begin
                if (count == '0) begin
                  res.status <= ST_BAD;
                  state      <= S_OUT;
                end else begin
                  state <= S_RD0;
                end
              end
              default: begin
                res.status <= ST_BAD;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_RD0: begin
          prev  <= rdata;
          cur   <= rdata;
          lo_ok <= (prm >= rdata.knot);
          state <= S_RDL;
        end
        S_RDL: begin
          hi_ok <= (prm <= rdata.knot);
          idx   <= AW'(1);
          found <= 1'b0;
          state <= (count == CW'(1)) ? S_DECIDE : S_SCAN;
        end
        S_SCAN: begin
          if (prm <= rdata.knot) begin
            cur   <= rdata;
            found <= 1'b1;
            state <= S_DECIDE;
          end else begin
            prev <= rdata;
            if (CW'(idx) == CW'(count - 1'b1)) begin
              state <= S_DECIDE;
            end else begin
              idx <= AW'(idx + 1'b1);
            end
          end
        end
        S_DECIDE: begin
          res.deriv_ok  <= deriv;
          res.seg_index <= deriv ? seg_ext : 6'd0;
          res.dx        <= deriv ? cur.x - prev.x : 32'sd0;
          res.dy        <= deriv ? cur.y - prev.y : 32'sd0;
          res.dz        <= deriv ? cur.z - prev.z : 32'sd0;
          fc            <= FLD_X;
          if (lo_ok && hi_ok) begin
            res.status <= ST_OK;
            if (found && (den > 33'sd0)) begin
              rem   <= {2'b00, num_cl};
              dvs   <= den[31:0];
              quot  <= '0;
              dcnt  <= DW'(QUOT_BITS - 1);
              state <= S_DIV;
            end else begin
              tfrac <= '0;
              state <= S_MUL;
            end
          end else begin
            res.status <= ST_BAD;
            state      <= S_OUT;
          end
        end
        S_DIV: begin
          rem  <= qbit ? trial - {2'b00, dvs} : trial;
          quot <= quot_next;
          if (dcnt == '0) begin
            tfrac <= quot_next;
            state <= S_MUL;
          end else begin
            dcnt <= dcnt - 1'b1;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, tfrac}) * fdiff;
          state <= S_ADD;
        end
        S_ADD: begin
          case (fc)
            FLD_X:   res.px      <= fsum;
            FLD_Y:   res.py      <= fsum;
            FLD_Z:   res.pz      <= fsum;
            default: res.pweight <= fsum;
          endcase
          if (fc == FLD_W) begin
            state <= S_OUT;
          end else begin
            fc    <= fc + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            res   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/polyline_point_evaluator_test.sv =====
`timescale 1ns / 1ps
// Testbench for polyline_point_evaluator: directed and random item streams, checked
// field by field against a built-in predictor of the vertex table and interpolation.
// Depends on ppe_pkg, ppe_req_if, ppe_rsp_if and the block itself.
module polyline_point_evaluator_test;
  import ppe_pkg::*;

  localparam int MAX_PTS = 64;
  localparam int RANDOM_ITEMS = 830;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vweight;
    logic signed [31:0] vknot;
    logic signed [31:0] param;
  } request_t;

  logic clk;
  logic rst;

  ppe_req_if req_ch();
  ppe_rsp_if rsp_ch();

  polyline_point_evaluator #(.MAX_POINTS(MAX_PTS)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  vertex_t vtx_store [MAX_PTS];
  int      vtx_count = 0;
  result_t pending_results [$];
  int      error_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  bit      no_gaps = 0;
  int      hold_cycles = 0;
  longint  cycle_count = 0;

  initial clk = 0;
  always #10 clk = ~clk;

  task automatic report_error(string msg);
    if (error_count < 100) begin
      $display("%0t ERROR %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d field %s: got %h expected %h",
                             results_seen, name, got, want));
    end
  endtask

  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] a,
                                                  logic signed [31:0] b, longint t);
    longint p;
    longint q;
    p = t * (longint'(b) - longint'(a));
    if (p >= 0) begin
      q = p / 65536;
    end else begin
      q = -((-p + 65535) / 65536);
    end
    return 32'(longint'(a) + q);
  endfunction

  function automatic result_t evaluate_request(request_t it);
    result_t            r;
    int                 n;
    int                 i;
    int                 lo;
    int                 hi;
    longint             num;
    longint             den;
    longint             t;
    logic signed [31:0] prm;
    r = '0;
    prm = it.param;
    case (it.func)
      FUNC_CLEAR: begin
        vtx_count = 0;
        r.status = ST_LOAD;
      end
      FUNC_APPEND: begin
        if (vtx_count >= MAX_PTS) begin
          r.status = ST_FULL;
        end else begin
          vtx_store[vtx_count].x = it.vx;
          vtx_store[vtx_count].y = it.vy;
          vtx_store[vtx_count].z = it.vz;
          vtx_store[vtx_count].weight = it.vweight;
          vtx_store[vtx_count].knot = it.vknot;
          vtx_count++;
          r.status = ST_LOAD;
        end
      end
      FUNC_EVAL: begin
        n = vtx_count;
        r.status = ST_BAD;
        if (n > 0) begin
          if (prm >= vtx_store[0].knot && prm <= vtx_store[n - 1].knot) begin
            i = 1;
            while (i < n && prm > vtx_store[i].knot) i++;
            lo = 0;
            hi = 0;
            t = 0;
            if (i < n) begin
              num = longint'(prm) - longint'(vtx_store[i - 1].knot);
              den = longint'(vtx_store[i].knot) - longint'(vtx_store[i - 1].knot);
              lo = i - 1;
              hi = i;
              if (den > 0) begin
                if (num < 0) num = 0;
                if (num > den) num = den;
                t = (num * 65536) / den;
              end
            end
            r.status = ST_OK;
            r.px = lerp_q16(vtx_store[lo].x, vtx_store[hi].x, t);
            r.py = lerp_q16(vtx_store[lo].y, vtx_store[hi].y, t);
            r.pz = lerp_q16(vtx_store[lo].z, vtx_store[hi].z, t);
            r.pweight = lerp_q16(vtx_store[lo].weight, vtx_store[hi].weight, t);
          end
        end
        if (prm >= 0) begin
          i = 1;
          while (i < n && prm > vtx_store[i].knot) i++;
          if (i < n) begin
            r.seg_index = 6'(i - 1);
            r.deriv_ok = 1'b1;
            r.dx = vtx_store[i].x - vtx_store[i - 1].x;
            r.dy = vtx_store[i].y - vtx_store[i - 1].y;
            r.dz = vtx_store[i].z - vtx_store[i - 1].z;
          end
        end
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic signed [31:0] near_q16();
    return 32'(longint'($urandom_range(0, 'h200000)) - 1048576);
  endfunction

  task automatic send_item(request_t it);
    int gap;
    @(negedge clk);
    req_ch.func = it.func;
    req_ch.vx = it.vx;
    req_ch.vy = it.vy;
    req_ch.vz = it.vz;
    req_ch.vweight = it.vweight;
    req_ch.vknot = it.vknot;
    req_ch.param = it.param;
    req_ch.valid = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(evaluate_request(it));
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_append(logic signed [31:0] x, y, z, w, k);
    request_t it;
    it.func = FUNC_APPEND;
    it.vx = x;
    it.vy = y;
    it.vz = z;
    it.vweight = w;
    it.vknot = k;
    it.param = $urandom;
    send_item(it);
  endtask

  task automatic send_eval(logic signed [31:0] p);
    request_t it;
    it.func = FUNC_EVAL;
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    it.vweight = $urandom;
    it.vknot = $urandom;
    it.param = p;
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] f);
    request_t it;
    it.func = f;
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    it.vweight = $urandom;
    it.vknot = $urandom;
    it.param = $urandom;
    send_item(it);
  endtask

  task automatic test_empty_and_unknown();
    send_eval(32'sh0);
    send_eval($urandom);
    send_op(FUNC_UNUSED);
    send_op(FUNC_CLEAR);
  endtask

  task automatic test_extremes();
    send_op(FUNC_CLEAR);
    send_append(32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh00010000, 32'sh80000000);
    send_append(32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh0);
    send_append(32'sh00010000, 32'sh0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    send_append(32'shFFFFFFFF, 32'sh12345678, 32'sh80000000, 32'sh0, 32'sh7FFFFFFF);
    send_eval(32'sh80000000);
    send_eval(32'shC0000000);
    send_eval(32'sh0);
    send_eval(32'sh1);
    send_eval(32'sh7FFFFFFF);
  endtask

  task automatic test_single_vertex();
    send_op(FUNC_CLEAR);
    send_append($urandom, $urandom, $urandom, $urandom, 32'sh00018000);
    send_eval(32'sh00018000);
    send_eval(32'sh00018001);
  endtask

  task automatic test_zero_interval();
    send_op(FUNC_CLEAR);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00020000);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00020000);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00030000);
    send_eval(32'sh00020000);
    send_eval(32'sh00028000);
    send_eval(32'sh0001FFFF);
  endtask

  task automatic test_out_of_order();
    send_op(FUNC_CLEAR);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00030000);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00010000);
    send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'sh00050000);
    send_eval(32'sh00008000);
    send_eval(32'sh00040000);
    send_eval(32'sh00020000);
  endtask

  task automatic test_full_table();
    int k;
    send_op(FUNC_CLEAR);
    for (k = 0; k < MAX_PTS; k++) begin
      send_append($urandom, $urandom, $urandom, $urandom, 32'(k * 'h10000));
    end
    send_append($urandom, $urandom, $urandom, $urandom, 32'(MAX_PTS * 'h10000));
    send_eval(32'((MAX_PTS - 1) * 'h10000 - 'h8000));
    send_eval(32'sh7FFFFFFF);
    send_eval(32'sh0);
    send_eval(-32'sd1);
  endtask

  task automatic test_backpressure();
    int k;
    no_gaps = 1;
    hold_cycles = HOLD_OFF_CYCLES;
    send_op(FUNC_CLEAR);
    for (k = 0; k < 4; k++) begin
      send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'(k * 'h4000));
    end
    repeat (6) send_eval(32'($urandom_range(0, 'hC000)));
    no_gaps = 0;
  endtask

  task automatic test_random_polylines();
    longint knots [MAX_PTS];
    longint kv;
    longint p;
    int     n;
    int     k;
    int     j;
    int     r;
    int     start;
    bit     disorder;
    bit     wide;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: send_op(FUNC_UNUSED);
            1: send_eval($urandom);
            2: send_append($urandom, $urandom, $urandom, $urandom, $urandom);
            default: send_op(2'($urandom));
          endcase
        end
      end else begin
        disorder = (r < 16);
        wide = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        n = (r < 75) ? $urandom_range(1, 10) :
            (r < 95) ? $urandom_range(11, 40) : $urandom_range(60, MAX_PTS);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: kv = longint'($urandom_range(0, 'h20000));
          4, 5, 6: kv = -longint'($urandom_range(0, 'h40000));
          7: kv = longint'(int'($urandom));
          8: kv = Q_MIN;
          default: kv = longint'($urandom_range(0, 'h7FFF0000));
        endcase
        send_op(FUNC_CLEAR);
        for (k = 0; k < n; k++) begin
          if (k > 0) begin
            if (disorder) begin
              kv = longint'($urandom_range(0, 'h80000)) - 131072;
            end else begin
              case ($urandom_range(0, 19))
                0, 1, 2: kv = kv;
                3, 4: kv = kv + longint'($urandom);
                default: kv = kv + longint'($urandom_range(1, 'h30000));
              endcase
              if (kv > Q_MAX) kv = Q_MAX;
            end
          end
          knots[k] = kv;
          if (wide) begin
            send_append($urandom, $urandom, $urandom, $urandom, 32'(kv));
          end else begin
            send_append(near_q16(), near_q16(), near_q16(), near_q16(), 32'(kv));
          end
        end
        if (n == MAX_PTS && $urandom_range(0, 1)) begin
          send_append($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        repeat ($urandom_range(2, 8)) begin
          r = $urandom_range(0, 99);
          j = (n > 1) ? $urandom_range(1, n - 1) : 0;
          if (r < 55 && n > 1 && knots[j] > knots[j - 1]) begin
            p = knots[j - 1] + longint'($urandom_range(0, 32'(knots[j] - knots[j - 1])));
          end else if (r < 70) begin
            p = knots[$urandom_range(0, n - 1)];
          end else if (r < 80) begin
            p = knots[0] - longint'($urandom_range(1, 'h10000));
          end else if (r < 90) begin
            p = knots[n - 1] + longint'($urandom_range(1, 'h10000));
          end else begin
            p = longint'(int'($urandom));
          end
          if (p < Q_MIN) p = Q_MIN;
          if (p > Q_MAX) p = Q_MAX;
          send_eval(32'(p));
        end
      end
    end
    no_gaps = 0;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.px = rsp_ch.px;
      got.py = rsp_ch.py;
      got.pz = rsp_ch.pz;
      got.pweight = rsp_ch.pweight;
      got.seg_index = rsp_ch.seg_index;
      got.deriv_ok = rsp_ch.deriv_ok;
      got.dx = rsp_ch.dx;
      got.dy = rsp_ch.dy;
      got.dz = rsp_ch.dz;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with no item waiting, status %0d", got.status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", got.status, want.status);
        check_field("px", got.px, want.px);
        check_field("py", got.py, want.py);
        check_field("pz", got.pz, want.pz);
        check_field("pweight", got.pweight, want.pweight);
        check_field("seg_index", got.seg_index, want.seg_index);
        check_field("deriv_ok", got.deriv_ok, want.deriv_ok);
        check_field("dx", got.dx, want.dx);
        check_field("dy", got.dy, want.dy);
        check_field("dz", got.dz, want.dz);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polyline_point_evaluator verification failed");
      $finish;
    end
  end

  initial begin
    int gap;
    int burst;
    int held;
    rsp_ch.ready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        held = hold_cycles;
        hold_cycles = 0;
        @(negedge clk);
        rsp_ch.ready = 1'b0;
        repeat (held - 1) @(negedge clk);
      end
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        rsp_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready = 1'b1;
      burst = $urandom_range(1, 8);
      repeat (burst - 1) @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_CLEAR;
    req_ch.vx = '0;
    req_ch.vy = '0;
    req_ch.vz = '0;
    req_ch.vweight = '0;
    req_ch.vknot = '0;
    req_ch.param = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_unknown();
    test_extremes();
    test_single_vertex();
    test_zero_interval();
    test_out_of_order();
    test_full_table();
    test_backpressure();
    test_random_polylines();

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("polyline_point_evaluator verification clean");
    end else begin
      $display("polyline_point_evaluator verification failed");
    end
    $finish;
  end

endmodule
